/* rtl/core/ps2_mouse_packet_decoder_unit_defines.svh */
// Assertion macros for the PS/2 mouse packet decoder RTL.
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled in reset.
`define PMD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2 mouse decoder: same-cycle check failed");

// Next-cycle implication, checked on clk, disabled in reset.
`define PMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2 mouse decoder: next-cycle check failed");

`endif

/* rtl/core/ps2md_pkg.sv */
// Shared constants and types for the PS/2 mouse packet decoder.
`default_nettype none

package ps2md_pkg;

    localparam int COORD_BITS_DEF   = 13;
    localparam int BUTTON_COUNT_DEF = 3;

    localparam int LIMIT_BITS  = 13;
    localparam int BUTTON_BITS = 3;
    localparam int SYNC_BIT    = 3;   // header byte bit that must be set

    localparam logic [LIMIT_BITS-1:0] WIDTH_LIMIT_RESET  = 13'd1920;
    localparam logic [LIMIT_BITS-1:0] HEIGHT_LIMIT_RESET = 13'd1080;

    // Configuration register indexes
    localparam logic CFG_WIDTH_LIMIT  = 1'b0;
    localparam logic CFG_HEIGHT_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        EV_MOVE   = 2'd0,
        EV_DOWN   = 2'd1,
        EV_UP     = 2'd2,
        EV_STATUS = 2'd3
    } event_kind_t;

    // One decoded packet handed from decoder to emitter
    typedef struct packed {
        logic signed [7:0]        dx;
        logic signed [8:0]        dy;
        logic [BUTTON_BITS-1:0]   buttons;
        logic [BUTTON_BITS-1:0]   changed;
    } pkt_t;

endpackage

`default_nettype wire

/* rtl/core/ps2md_decode.sv */
// Byte framing, cursor update and button diff for one PS/2 packet.
`default_nettype none

module ps2md_decode #(
    parameter int COORD_BITS   = ps2md_pkg::COORD_BITS_DEF,
    parameter int BUTTON_COUNT = ps2md_pkg::BUTTON_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic [ps2md_pkg::LIMIT_BITS-1:0] width_limit,
    input  logic [ps2md_pkg::LIMIT_BITS-1:0] height_limit,
    input  logic                           slot_ready,
    output logic                           pkt_valid,
    output ps2md_pkg::pkt_t                pkt,
    output logic [COORD_BITS-1:0]          pkt_pos_x,
    output logic [COORD_BITS-1:0]          pkt_pos_y
);
    import ps2md_pkg::*;

    localparam int SUM_W = ((COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS) + 2;
    localparam logic [BUTTON_BITS-1:0] BTN_MASK = BUTTON_BITS'((1 << BUTTON_COUNT) - 1);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              header_reg, header_next;
    logic [7:0]              xbyte_reg, xbyte_next;
    logic [COORD_BITS-1:0]   pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]   pos_y_reg, pos_y_next;
    logic [BUTTON_BITS-1:0]  held_reg, held_next;

    logic                    accept;
    logic signed [7:0]       dx;
    logic signed [8:0]       dy;
    logic [BUTTON_BITS-1:0]  new_b;
    logic [COORD_BITS-1:0]   new_x, new_y;

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic [COORD_BITS-1:0]  pos,
        input logic signed [8:0]      delta,
        input logic [LIMIT_BITS-1:0]  limit
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] lim;
        sum = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos}) + SUM_W'(delta);
        lim = $signed({{(SUM_W-LIMIT_BITS){1'b0}}, limit});
        if (limit == '0)
        begin
            lim = SUM_W'(1);  // zero limit behaves as one
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        else if (sum >= lim)
        begin
            sum = lim - SUM_W'(1);
        end
        return sum[COORD_BITS-1:0];
    endfunction

    assign in_ready = (phase_reg != PH_Y) || slot_ready;
    assign accept   = in_valid && in_ready;

    assign dx    = $signed(xbyte_reg);
    assign dy    = -$signed({data_byte[7], data_byte});
    assign new_b = header_reg[BUTTON_BITS-1:0] & BTN_MASK;
    assign new_x = clamp_axis(pos_x_reg, 9'(dx), width_limit);
    assign new_y = clamp_axis(pos_y_reg, dy, height_limit);

    assign pkt_valid   = accept && (phase_reg == PH_Y);
    assign pkt.dx      = dx;
    assign pkt.dy      = dy;
    assign pkt.buttons = new_b;
    assign pkt.changed = (held_reg & BTN_MASK) ^ new_b;
    assign pkt_pos_x   = new_x;
    assign pkt_pos_y   = new_y;

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xbyte_next  = xbyte_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        held_next   = held_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_X:
                begin
                    xbyte_next = data_byte;
                    phase_next = PH_Y;
                end
                PH_Y:
                begin
                    pos_x_next = new_x;
                    pos_y_next = new_y;
                    held_next  = new_b;
                    phase_next = PH_HEADER;
                end
                default:
                begin
                    // header hunt; unused phase code behaves the same
                    header_next = data_byte;
                    phase_next  = data_byte[SYNC_BIT] ? PH_X : PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            xbyte_reg  <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            held_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            xbyte_reg  <= xbyte_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            held_reg   <= held_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ps2md_emit.sv */
// Serializes one decoded packet into move, button and status events.
`default_nettype none

`include "ps2_mouse_packet_decoder_unit_defines.svh"

module ps2md_emit #(
    parameter int COORD_BITS = ps2md_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pkt_valid,
    input  ps2md_pkg::pkt_t                  pkt,
    input  logic [COORD_BITS-1:0]            pkt_pos_x,
    input  logic [COORD_BITS-1:0]            pkt_pos_y,
    output logic                             slot_ready,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       event_kind,
    output logic [COORD_BITS-1:0]            cursor_x,
    output logic [COORD_BITS-1:0]            cursor_y,
    output logic signed [7:0]                delta_x,
    output logic signed [8:0]                delta_y,
    output logic [ps2md_pkg::BUTTON_BITS-1:0] button_bits,
    output logic [ps2md_pkg::BUTTON_BITS-1:0] changed_mask,
    output logic                             last_of_run
);
    import ps2md_pkg::*;

    // pending work for the held packet
    logic                    pend_move_reg, pend_move_next;
    logic [BUTTON_BITS-1:0]  pend_btn_reg, pend_btn_next;
    logic                    pend_stat_reg, pend_stat_next;
    pkt_t                    pkt_reg;
    logic [COORD_BITS-1:0]   px_reg, py_reg;

    // output register
    logic                    out_valid_reg, out_valid_next;
    event_kind_t             kind_reg, kind_next;
    logic signed [7:0]       dx_reg, dx_next;
    logic signed [8:0]       dy_reg, dy_next;
    logic [BUTTON_BITS-1:0]  mask_reg, mask_next;
    logic                    last_reg, last_next;

    logic                    pend_any, out_free, issue;
    logic                    after_move, after_stat;
    logic [BUTTON_BITS-1:0]  after_btn, pick;
    logic                    after_none;

    assign pend_any = pend_move_reg || (pend_btn_reg != '0) || pend_stat_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign issue    = out_free && pend_any;
    assign pick     = pend_btn_reg & (~pend_btn_reg + BUTTON_BITS'(1));  // lowest pending

    always_comb
    begin
        after_move = pend_move_reg;
        after_btn  = pend_btn_reg;
        after_stat = pend_stat_reg;
        kind_next  = kind_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        mask_next  = mask_reg;
        if (pend_move_reg)
        begin
            after_move = 1'b0;
            kind_next  = EV_MOVE;
            dx_next    = pkt_reg.dx;
            dy_next    = pkt_reg.dy;
            mask_next  = '0;
        end
        else if (pend_btn_reg != '0)
        begin
            after_btn = pend_btn_reg & ~pick;
            kind_next = ((pkt_reg.buttons & pick) != '0) ? EV_DOWN : EV_UP;
            dx_next   = '0;
            dy_next   = '0;
            mask_next = pick;
        end
        else
        begin
            after_stat = 1'b0;
            kind_next  = EV_STATUS;
            dx_next    = '0;
            dy_next    = '0;
            mask_next  = '0;
        end
        after_none = !after_move && (after_btn == '0) && !after_stat;
        last_next  = after_none;
    end

    assign slot_ready = !pend_any || (out_free && after_none);

    always_comb
    begin
        pend_move_next = pend_move_reg;
        pend_btn_next  = pend_btn_reg;
        pend_stat_next = pend_stat_reg;
        if (issue)
        begin
            pend_move_next = after_move;
            pend_btn_next  = after_btn;
            pend_stat_next = after_stat;
        end
        if (pkt_valid)
        begin
            pend_move_next = (pkt.dx != '0) || (pkt.dy != '0);
            pend_btn_next  = pkt.changed;
            pend_stat_next = (pkt.dx == '0) && (pkt.dy == '0) && (pkt.changed == '0);
        end
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_move_reg <= 1'b0;
            pend_btn_reg  <= '0;
            pend_stat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_move_reg <= pend_move_next;
            pend_btn_reg  <= pend_btn_next;
            pend_stat_reg <= pend_stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid)
        begin
            pkt_reg <= pkt;
            px_reg  <= pkt_pos_x;
            py_reg  <= pkt_pos_y;
        end
        if (issue)
        begin
            kind_reg    <= kind_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            mask_reg    <= mask_next;
            last_reg    <= last_next;
            cursor_x    <= px_reg;
            cursor_y    <= py_reg;
            button_bits <= pkt_reg.buttons;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign delta_x      = dx_reg;
    assign delta_y      = dy_reg;
    assign changed_mask = mask_reg;
    assign last_of_run  = last_reg;

    `PMD_ASSERT_SAME(a_load_only_when_free, pkt_valid, !pend_any || (issue && after_none))
    `PMD_ASSERT_NEXT(a_load_sets_work, pkt_valid, pend_any)
    `PMD_ASSERT_SAME(a_single_changed_bit, out_valid_reg, $onehot0(mask_reg))
    `PMD_ASSERT_SAME(a_move_has_delta, out_valid_reg && (kind_reg == EV_MOVE),
                     (dx_reg != '0) || (dy_reg != '0))

endmodule

`default_nettype wire

/* rtl/core/ps2_mouse_packet_decoder_unit.sv */
// PS/2 mouse three-byte packet decoder: top level with limit registers.
// Header and X bytes: accepted one per cycle, no events.
// Third byte: the packet goes to the emitter's packet slot, then its first
// event to the output register once that is free; a packet gives 1 to 4
// events, one per cycle while out_ready is high; the next third byte waits until the emitter's packet slot drains.
// Async active-low reset: cursor at 0,0, buttons released, header hunt,
// limits 1920 x 1080, no events pending.
`default_nettype none

module ps2_mouse_packet_decoder_unit #(
    parameter int COORD_BITS   = ps2md_pkg::COORD_BITS_DEF,
    parameter int BUTTON_COUNT = ps2md_pkg::BUTTON_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [ps2md_pkg::LIMIT_BITS-1:0]  cfg_data,
    // byte input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        data_byte,
    // event output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        event_kind,
    output logic [COORD_BITS-1:0]             cursor_x,
    output logic [COORD_BITS-1:0]             cursor_y,
    output logic signed [7:0]                 delta_x,
    output logic signed [8:0]                 delta_y,
    output logic [ps2md_pkg::BUTTON_BITS-1:0] button_bits,
    output logic [ps2md_pkg::BUTTON_BITS-1:0] changed_mask,
    output logic                              last_of_run
);
    import ps2md_pkg::*;

    logic [LIMIT_BITS-1:0]  width_limit_reg;
    logic [LIMIT_BITS-1:0]  height_limit_reg;

    logic                   slot_ready;
    logic                   pkt_valid;
    pkt_t                   pkt;
    logic [COORD_BITS-1:0]  pkt_pos_x, pkt_pos_y;

    // Limits: user writes only while no transaction is in flight; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_limit_reg  <= WIDTH_LIMIT_RESET;
            height_limit_reg <= HEIGHT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH_LIMIT:  width_limit_reg  <= cfg_data;
                CFG_HEIGHT_LIMIT: height_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Framing and cursor math; produces a packet on each accepted third byte.
    ps2md_decode #(
        .COORD_BITS   (COORD_BITS),
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .width_limit  (width_limit_reg),
        .height_limit (height_limit_reg),
        .slot_ready   (slot_ready),
        .pkt_valid    (pkt_valid),
        .pkt          (pkt),
        .pkt_pos_x    (pkt_pos_x),
        .pkt_pos_y    (pkt_pos_y)
    );

    // Packet slot plus output register; splits a packet into its events.
    ps2md_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .pkt_valid    (pkt_valid),
        .pkt          (pkt),
        .pkt_pos_x    (pkt_pos_x),
        .pkt_pos_y    (pkt_pos_y),
        .slot_ready   (slot_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .button_bits  (button_bits),
        .changed_mask (changed_mask),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire
